[sv/ifrp_pkg.sv]
`default_nettype none

package ifrp_pkg;

	localparam int MW  = 64;  // mantissa and packed word width
	localparam int XW  = 32;  // input exponent width
	localparam int EW  = 34;  // internal exponent width, never wraps
	localparam int SW  = 6;   // shift amount width
	localparam int LZW = 6;   // leading-zero count width
	localparam int EFW = 11;  // widest biased exponent field

	localparam logic FUNC_SINGLE = 1'b0;
	localparam logic FUNC_DOUBLE = 1'b1;

	localparam logic [1:0] KIND_NORMAL = 2'd0;
	localparam logic [1:0] KIND_INF    = 2'd1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_OVF_NEG = 2'd1,
		STAT_OVF_POS = 2'd2
	} status_t;

	localparam int SGL_FRAC = 23;
	localparam int DBL_FRAC = 52;
	localparam int SGL_BIAS = 127;
	localparam int DBL_BIAS = 1023;

	localparam logic [SW-1:0] SGL_NSHIFT = 6'd40;
	localparam logic [SW-1:0] DBL_NSHIFT = 6'd11;
	localparam logic [SW-1:0] SGL_SIGN   = 6'd31;
	localparam logic [SW-1:0] DBL_SIGN   = 6'd63;

	localparam logic [MW-1:0] TOP_BIT       = 64'h8000000000000000;
	localparam logic [MW-1:0] SGL_TOP_ONES  = 64'hffffff0000000000;
	localparam logic [MW-1:0] DBL_TOP_ONES  = 64'hfffffffffffff800;
	localparam logic [MW-1:0] SGL_OVF_BOUND = 64'hffffff8000000000;
	localparam logic [MW-1:0] DBL_OVF_BOUND = 64'hfffffffffffffc00;
	localparam logic [MW-1:0] SGL_QNAN      = 64'h000000007fc00000;
	localparam logic [MW-1:0] SGL_INF       = 64'h000000007f800000;
	localparam logic [MW-1:0] DBL_QNAN      = 64'h7ff8000000000000;
	localparam logic [MW-1:0] DBL_INF       = 64'h7ff0000000000000;

	localparam logic signed [EW-1:0] E_ONE    = 34'sd1;
	localparam logic signed [EW-1:0] E_TOPPOS = 34'sd63;

	typedef struct packed {
		logic [MW-1:0]        mant;
		logic signed [EW-1:0] expo;
	} norm_t;

endpackage

`default_nettype wire

[sv/ifrp_norm.sv]
`default_nettype none

module ifrp_norm (
	input  wire logic [ifrp_pkg::MW-1:0]        mantissa,
	input  wire logic signed [ifrp_pkg::XW-1:0] exponent,
	output ifrp_pkg::norm_t                     nrm
);

	logic [ifrp_pkg::MW-1:0]  v;
	logic [ifrp_pkg::LZW-1:0] lz;

	// binary search for the leading one: halves, quarters, ... of the word
	always_comb begin
		v = mantissa;
		lz = '0;
		for (int i = ifrp_pkg::LZW - 1; i >= 0; i--) begin
			if ((v >> (ifrp_pkg::MW - (1 << i))) == '0) begin
				v = v << (1 << i);
				lz[i] = 1'b1;
			end
		end
	end

	// value becomes mant * 2^(expo - 63) with the top bit of mant set
	always_comb begin
		nrm.mant = v;
		nrm.expo = {{(ifrp_pkg::EW - ifrp_pkg::XW){exponent[ifrp_pkg::XW-1]}}, exponent}
			- {{(ifrp_pkg::EW - ifrp_pkg::LZW){1'b0}}, lz} + ifrp_pkg::E_TOPPOS;
	end

endmodule

`default_nettype wire

[sv/ifrp_round.sv]
`default_nettype none

module ifrp_round (
	input  wire logic [ifrp_pkg::MW-1:0] mant,
	input  wire logic [ifrp_pkg::SW-1:0] rshift,
	output logic [ifrp_pkg::MW-1:0]      q
);

	logic [ifrp_pkg::MW-1:0] trunc;
	logic [ifrp_pkg::MW-1:0] below_mask;
	logic [ifrp_pkg::SW-1:0] gpos;
	logic                    guard;
	logic                    sticky;

	// round to nearest, ties to even; rshift is never zero when q is used
	always_comb begin
		gpos = rshift - ifrp_pkg::SW'(1);
		trunc = mant >> rshift;
		guard = mant[gpos];
		below_mask = (ifrp_pkg::MW'(1) << gpos) - ifrp_pkg::MW'(1);
		sticky = |(mant & below_mask);
		q = trunc + {{(ifrp_pkg::MW - 1){1'b0}}, guard & (sticky | trunc[0])};
	end

endmodule

`default_nettype wire

[sv/ieee_float_round_pack_unit.sv]
`default_nettype none

// Packs sign, 64-bit integer mantissa and signed binary exponent into IEEE-754
// single (func 0, low 32 bits of packed_bits) or double (func 1) precision,
// rounding to nearest with ties to even and producing denormals, signed zeros,
// infinities and the canonical quiet NaN. A magnitude too large for the format
// gives packed_bits zero and an overflow status by sign. Throughput is one
// transaction per cycle while res_stall is low; each transaction passes
// through an input register and a result register, with the normalize, round
// and pack logic in a single pass between them. A held result stalls the
// input side only when both registers are full.
module ieee_float_round_pack_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               arg_valid,
	output logic                                    arg_stall,
	input  wire logic                               func,
	input  wire logic [1:0]                         kind,
	input  wire logic                               negative,
	input  wire logic [ifrp_pkg::MW-1:0]            mantissa,
	input  wire logic signed [ifrp_pkg::XW-1:0]     exponent,
	output logic                                    res_valid,
	input  wire logic                               res_stall,
	output logic [ifrp_pkg::MW-1:0]                 packed_bits,
	output logic [1:0]                              status
);

	logic                              valid_s1;
	logic                              func_s1;
	logic [1:0]                        kind_s1;
	logic                              neg_s1;
	logic [ifrp_pkg::MW-1:0]           mant_s1;
	logic signed [ifrp_pkg::XW-1:0]    exp_s1;

	logic                              valid_s2;
	logic [ifrp_pkg::MW-1:0]           bits_s2;
	logic [1:0]                        status_s2;

	logic                              adv_s2;
	logic                              load_s1;

	ifrp_pkg::norm_t                   nrm;
	logic [ifrp_pkg::MW-1:0]           m2;
	logic signed [ifrp_pkg::EW-1:0]    e2;
	logic signed [ifrp_pkg::EW-1:0]    bias_e;
	logic signed [ifrp_pkg::EW-1:0]    neg_bias;
	logic signed [ifrp_pkg::EW-1:0]    low_e;
	logic signed [ifrp_pkg::EW-1:0]    den_amt;
	logic signed [ifrp_pkg::EW-1:0]    base_full;
	logic [ifrp_pkg::SW-1:0]           nshift;
	logic [ifrp_pkg::SW-1:0]           frac_sh;
	logic [ifrp_pkg::SW-1:0]           sign_sh;
	logic [ifrp_pkg::SW-1:0]           rshift;
	logic [ifrp_pkg::MW-1:0]           top_ones;
	logic [ifrp_pkg::MW-1:0]           ovf_bound;
	logic [ifrp_pkg::MW-1:0]           qnan_v;
	logic [ifrp_pkg::MW-1:0]           inf_v;
	logic                              is_zero;
	logic                              is_norm;
	logic                              is_den;
	logic                              is_nan;
	logic [ifrp_pkg::MW-1:0]           q;
	logic [ifrp_pkg::EFW-1:0]          exp_base;
	logic [ifrp_pkg::MW-1:0]           mag;
	logic [ifrp_pkg::MW-1:0]           sign_word;
	logic [ifrp_pkg::MW-1:0]           bits_d;
	ifrp_pkg::status_t                 status_d;

	assign adv_s2    = !valid_s2 || !res_stall;
	assign load_s1   = !valid_s1 || adv_s2;
	assign arg_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= arg_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && arg_valid) begin
			func_s1 <= func;
			kind_s1 <= kind;
			neg_s1  <= negative;
			mant_s1 <= mantissa;
			exp_s1  <= exponent;
		end
		if (adv_s2 && valid_s1) begin
			bits_s2   <= bits_d;
			status_s2 <= status_d;
		end
	end

	ifrp_norm u_norm (
		.mantissa (mant_s1),
		.exponent (exp_s1),
		.nrm      (nrm)
	);

	// format constants
	always_comb begin
		if (func_s1 == ifrp_pkg::FUNC_DOUBLE) begin
			bias_e    = ifrp_pkg::EW'(ifrp_pkg::DBL_BIAS);
			low_e     = -ifrp_pkg::EW'(ifrp_pkg::DBL_BIAS + ifrp_pkg::DBL_FRAC);
			frac_sh   = ifrp_pkg::SW'(ifrp_pkg::DBL_FRAC);
			nshift    = ifrp_pkg::DBL_NSHIFT;
			sign_sh   = ifrp_pkg::DBL_SIGN;
			top_ones  = ifrp_pkg::DBL_TOP_ONES;
			ovf_bound = ifrp_pkg::DBL_OVF_BOUND;
			qnan_v    = ifrp_pkg::DBL_QNAN;
			inf_v     = ifrp_pkg::DBL_INF;
		end else begin
			bias_e    = ifrp_pkg::EW'(ifrp_pkg::SGL_BIAS);
			low_e     = -ifrp_pkg::EW'(ifrp_pkg::SGL_BIAS + ifrp_pkg::SGL_FRAC);
			frac_sh   = ifrp_pkg::SW'(ifrp_pkg::SGL_FRAC);
			nshift    = ifrp_pkg::SGL_NSHIFT;
			sign_sh   = ifrp_pkg::SGL_SIGN;
			top_ones  = ifrp_pkg::SGL_TOP_ONES;
			ovf_bound = ifrp_pkg::SGL_OVF_BOUND;
			qnan_v    = ifrp_pkg::SGL_QNAN;
			inf_v     = ifrp_pkg::SGL_INF;
		end
		neg_bias = -bias_e;
	end

	// underflow edges: bump up to the next binade or flush to zero
	always_comb begin
		m2 = nrm.mant;
		e2 = nrm.expo;
		if (e2 == neg_bias) begin
			if (m2 >= top_ones) begin
				m2 = ifrp_pkg::TOP_BIT;
				e2 = e2 + ifrp_pkg::E_ONE;
			end
		end else if (e2 <= low_e) begin
			if (e2 == low_e && m2 > ifrp_pkg::TOP_BIT) begin
				m2 = ifrp_pkg::TOP_BIT;
				e2 = e2 + ifrp_pkg::E_ONE;
			end else begin
				m2 = '0;
				e2 = '0;
			end
		end

		is_zero = (m2 == '0);
		is_norm = (e2 > neg_bias && e2 < bias_e) || (e2 == bias_e && m2 < ovf_bound);
		is_den  = (e2 > low_e) && (e2 <= neg_bias);

		den_amt = {{(ifrp_pkg::EW - ifrp_pkg::SW){1'b0}}, nshift} + ifrp_pkg::E_ONE
			- bias_e - e2;
		rshift = is_norm ? nshift : den_amt[ifrp_pkg::SW-1:0];

		// hidden bit in q adds the last one to the exponent; carry bumps it again
		base_full = e2 + bias_e - ifrp_pkg::E_ONE;
		exp_base = is_norm ? base_full[ifrp_pkg::EFW-1:0] : '0;
	end

	ifrp_round u_round (
		.mant   (m2),
		.rshift (rshift),
		.q      (q)
	);

	always_comb begin
		is_nan = (kind_s1 != ifrp_pkg::KIND_NORMAL) && (kind_s1 != ifrp_pkg::KIND_INF);
		sign_word = {{(ifrp_pkg::MW - 1){1'b0}}, neg_s1} << sign_sh;
		mag = q + ({{(ifrp_pkg::MW - ifrp_pkg::EFW){1'b0}}, exp_base} << frac_sh);
		status_d = ifrp_pkg::STAT_OK;
		bits_d = '0;
		if (is_nan) begin
			bits_d = qnan_v;
		end else if (kind_s1 == ifrp_pkg::KIND_INF) begin
			bits_d = sign_word | inf_v;
		end else if (is_zero) begin
			bits_d = sign_word;
		end else if (is_norm || is_den) begin
			bits_d = sign_word | mag;
		end else begin
			status_d = neg_s1 ? ifrp_pkg::STAT_OVF_NEG : ifrp_pkg::STAT_OVF_POS;
		end
	end

	assign res_valid   = valid_s2;
	assign packed_bits = bits_s2;
	assign status      = status_s2;

endmodule

`default_nettype wire
